// File: hw/rtl/ccfe_pkg.sv
`default_nettype none

package ccfe_pkg;

   localparam int unsigned BLOCK_DEPTH = 254;
   localparam int unsigned ADDR_W = 8;

   localparam logic [7:0] BLOCK_MAX = 8'd254;
   localparam logic [7:0] FULL_CODE = 8'hFF;
   localparam logic [7:0] DELIM_BYTE = 8'h00;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   localparam logic [2:0] PH_DATA = 3'd0;
   localparam logic [2:0] PH_CRC_LO = 3'd1;
   localparam logic [2:0] PH_CRC_HI = 3'd2;
   localparam logic [2:0] PH_FINAL = 3'd3;
   localparam logic [2:0] PH_DELIM = 3'd4;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              wr2_en;
      logic [7:0]        wr2_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic       accepted;
      logic       out_valid;
      logic [7:0] out_byte;
      logic       frame_end;
      logic       from_mem;
   } result_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ccfe_req_if.sv
`default_nettype none

interface ccfe_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output action, output data_byte, output last_byte,
                   input ready);
   modport sink (input valid, input action, input data_byte, input last_byte,
                 output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ccfe_rsp_if.sv
`default_nettype none

interface ccfe_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source (output valid, output accepted, output out_valid, output out_byte,
                   output frame_end, input ready);
   modport sink (input valid, input accepted, input out_valid, input out_byte,
                 input frame_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ccfe_block_ram.sv
`default_nettype none

module ccfe_block_ram
   import ccfe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ram_req_type ram_req,
   output logic [7:0]       rd_data
);

   logic [7:0] block_store_mem [BLOCK_DEPTH];

   logic              pend_valid_ff;
   logic              pend_valid_in;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [ADDR_W-1:0] pend_addr_in;
   logic [7:0]        pend_data_ff;
   logic [7:0]        pend_data_in;
   logic [7:0]        rd_data_ff;

   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [7:0]        wdata;

   // second write of a cycle is registered and written next
   assign pend_valid_in = ram_req.wr2_en;
   assign pend_addr_in = ram_req.wr_addr + ADDR_W'(1);
   assign pend_data_in = ram_req.wr2_data;

   always_comb begin
      if (pend_valid_ff) begin
         we = 1'b1;
         waddr = pend_addr_ff;
         wdata = pend_data_ff;
      end else begin
         we = ram_req.wr_en;
         waddr = ram_req.wr_addr;
         wdata = ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         block_store_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         if (pend_valid_ff && (pend_addr_ff == ram_req.rd_addr)) begin
            rd_data_ff <= pend_data_ff;
         end else begin
            rd_data_ff <= block_store_mem[ram_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ccfe_ctrl.sv
`default_nettype none

module ccfe_ctrl
   import ccfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic       action,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output ram_req_type     ram_req,
   output result_type      result
);

   typedef struct packed {
      logic       wr;
      logic       close;
      logic [7:0] code;
      logic [7:0] fill;
   } feed_type;

   function automatic feed_type feed(input logic [7:0] fill, input logic [7:0] b);
      feed_type f;
      f.wr = 1'b0;
      f.close = 1'b0;
      f.code = FULL_CODE;
      f.fill = fill;
      if (fill >= BLOCK_MAX) begin
         f.close = 1'b1;
      end else if (b == 8'h00) begin
         f.close = 1'b1;
         f.code = fill + 8'd1;
      end else begin
         f.wr = 1'b1;
         f.fill = fill + 8'd1;
         if (f.fill >= BLOCK_MAX) begin
            f.close = 1'b1;
         end
      end
      return f;
   endfunction

   logic [7:0]  fill_ff, fill_in;
   logic [7:0]  pos_ff, pos_in;
   logic        busy_ff, busy_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  phase_ff, phase_in;

   feed_type    fp, fa, fb;
   logic [7:0]  hi_fill;
   logic [7:0]  pos_next;
   logic [7:0]  rd_idx;
   logic        do_close;
   logic [7:0]  close_code;

   always_comb begin
      fp = feed(fill_ff, data_byte);
      fa = feed(fill_ff, crc_ff[7:0]);
      hi_fill = (phase_ff == PH_CRC_LO) ? fa.fill : fill_ff;
      fb = feed(hi_fill, crc_ff[15:8]);
      pos_next = pos_ff + 8'd1;
      rd_idx = pos_ff - 8'd1;

      fill_in = fill_ff;
      pos_in = pos_ff;
      busy_in = busy_ff;
      code_in = code_ff;
      crc_in = crc_ff;
      phase_in = phase_ff;
      do_close = 1'b0;
      close_code = code_ff;

      ram_req = '0;
      ram_req.wr_addr = fill_ff;
      ram_req.rd_addr = rd_idx;
      result = '0;

      if (take) begin
         if (action == ACT_PUSH) begin
            if (!busy_ff && (phase_ff == PH_DATA)) begin
               result.accepted = 1'b1;
               crc_in = crc16_byte(crc_ff, data_byte);
               ram_req.wr_en = fp.wr;
               ram_req.wr_data = data_byte;
               fill_in = fp.fill;
               if (fp.close) begin
                  busy_in = 1'b1;
                  pos_in = 8'd0;
                  code_in = fp.code;
               end
               if (last_byte) begin
                  phase_in = PH_CRC_LO;
               end
            end
         end else if (busy_ff) begin
            result.out_valid = 1'b1;
            if (pos_ff == 8'd0) begin
               result.out_byte = code_ff;
            end else if (rd_idx < BLOCK_MAX) begin
               ram_req.rd_en = 1'b1;
               result.from_mem = 1'b1;
            end
            if (pos_next >= code_ff) begin
               busy_in = 1'b0;
               pos_in = 8'd0;
               fill_in = 8'd0;
            end else begin
               pos_in = pos_next;
            end
         end else begin
            unique case (phase_ff)
               PH_CRC_LO: begin
                  ram_req.wr_en = fa.wr;
                  ram_req.wr_data = crc_ff[7:0];
                  do_close = 1'b1;
                  if (fa.close) begin
                     fill_in = fa.fill;
                     close_code = fa.code;
                     phase_in = PH_CRC_HI;
                  end else begin
                     ram_req.wr2_en = fb.wr;
                     ram_req.wr2_data = crc_ff[15:8];
                     fill_in = fb.fill;
                     if (fb.close) begin
                        close_code = fb.code;
                        phase_in = PH_FINAL;
                     end else begin
                        close_code = fb.fill + 8'd1;
                        phase_in = PH_DELIM;
                     end
                  end
               end
               PH_CRC_HI: begin
                  ram_req.wr_en = fb.wr;
                  ram_req.wr_data = crc_ff[15:8];
                  do_close = 1'b1;
                  fill_in = fb.fill;
                  if (fb.close) begin
                     close_code = fb.code;
                     phase_in = PH_FINAL;
                  end else begin
                     close_code = fb.fill + 8'd1;
                     phase_in = PH_DELIM;
                  end
               end
               PH_FINAL: begin
                  do_close = 1'b1;
                  close_code = fill_ff + 8'd1;
                  phase_in = PH_DELIM;
               end
               PH_DELIM: begin
                  result.out_valid = 1'b1;
                  result.out_byte = DELIM_BYTE;
                  result.frame_end = 1'b1;
                  crc_in = CRC_INIT;
                  fill_in = 8'd0;
                  phase_in = PH_DATA;
               end
               default: begin
               end
            endcase
            // closed block sends its code byte in the same transaction
            if (do_close) begin
               result.out_valid = 1'b1;
               result.out_byte = close_code;
               code_in = close_code;
               if (close_code > 8'd1) begin
                  busy_in = 1'b1;
                  pos_in = 8'd1;
               end else begin
                  busy_in = 1'b0;
                  pos_in = 8'd0;
                  fill_in = 8'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 8'd0;
         pos_ff <= 8'd0;
         busy_ff <= 1'b0;
         code_ff <= 8'd0;
         crc_ff <= CRC_INIT;
         phase_ff <= PH_DATA;
      end else begin
         fill_ff <= fill_in;
         pos_ff <= pos_in;
         busy_ff <= busy_in;
         code_ff <= code_in;
         crc_ff <= crc_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/crc16_cobs_frame_encoder_core.sv
// response: registered, appears in the cycle after its request transaction
// throughput: one transaction per cycle while the response register is empty or being
//   taken; the control update is combinational and the block store read is registered
// reset: synchronous, clears control state, crc to 0xffff and the response valid flag;
//   the block store is not cleared
`default_nettype none

module crc16_cobs_frame_encoder_core
   import ccfe_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ccfe_req_if.sink   req_if,
   ccfe_rsp_if.source rsp_if
);

   logic        take;
   ram_req_type ram_req;
   result_type  result;
   logic [7:0]  rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       accepted_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       frame_end_ff;
   logic       from_mem_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign take = req_if.valid && req_if.ready;

   ccfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .action    (req_if.action),
      .data_byte (req_if.data_byte),
      .last_byte (req_if.last_byte),
      .ram_req   (ram_req),
      .result    (result)
   );

   ccfe_block_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         accepted_ff <= result.accepted;
         out_valid_ff <= result.out_valid;
         out_byte_ff <= result.out_byte;
         frame_end_ff <= result.frame_end;
         from_mem_ff <= result.from_mem;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.accepted = accepted_ff;
   assign rsp_if.out_valid = out_valid_ff;
   assign rsp_if.out_byte = from_mem_ff ? rd_data : out_byte_ff;
   assign rsp_if.frame_end = frame_end_ff;

endmodule

`default_nettype wire
